[hw/rtl/float32_square_root_core_defines.svh]
// Assertion macros for the square root core top module.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef FLOAT32_SQUARE_ROOT_CORE_DEFINES_SVH
`define FLOAT32_SQUARE_ROOT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("square root core check failed");
`define FSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("square root core check failed");
`else
`define FSR_ASSERT_NOW(label, ante, cons)
`define FSR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/fsr_pkg.sv]
// Types and constants of the single-precision square root core.
// Used by every module of the core; depends on nothing.
package fsr_pkg;
    localparam int unsigned RootBits = 25;
    localparam int unsigned RemBits  = 28;

    localparam logic [31:0] SignMask   = 32'h8000_0000;
    localparam logic [31:0] DefaultNan = 32'h7fc0_0000;
    localparam logic [31:0] HalfBias   = 32'h3f00_0000;
    localparam logic [9:0]  ExpBias    = 10'd127;

    localparam logic [1:0] RndNearest = 2'd0;
    localparam logic [1:0] RndTrunc   = 2'd1;
    localparam logic [1:0] RndUp      = 2'd2;

    typedef struct packed {
        logic                special;
        logic [31:0]         spec_bits;
        logic                invalid;
        logic signed [7:0]   exp_half;
        logic [RemBits-1:0]  rem;
        logic [RemBits-1:0]  partial;
        logic [RootBits-1:0] root;
        logic [RootBits-1:0] bit_oh;
    } fsr_work_t;
endpackage

[hw/rtl/fsr_norm.sv]
// Entry stage: classifies the operand, normalizes subnormals and halves the exponent.
// Depends on fsr_pkg.
module fsr_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       operand_bits,
    output logic              valid_reg,
    output fsr_pkg::fsr_work_t work_reg
);
    fsr_pkg::fsr_work_t work_next;
    logic [4:0]  msb;
    logic [4:0]  shifts;
    logic [7:0]  ex;
    logic [22:0] frac;
    logic [23:0] mant;
    logic [9:0]  e_unb;
    logic [24:0] mant_adj;

    always_comb
    begin
        ex   = operand_bits[30:23];
        frac = operand_bits[22:0];
        msb  = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (frac[i])
            begin
                msb = 5'(i);
            end
        end
        shifts = 5'd23 - msb;
        if (ex == 8'd0)
        begin
            mant  = {1'b0, frac} << shifts;
            e_unb = 10'd1 - {5'd0, shifts} - fsr_pkg::ExpBias;
        end
        else
        begin
            mant  = {1'b1, frac};
            e_unb = {2'd0, ex} - fsr_pkg::ExpBias;
        end
        mant_adj = e_unb[0] ? {mant, 1'b0} : {1'b0, mant};

        work_next.special   = 1'b0;
        work_next.spec_bits = operand_bits;
        work_next.invalid   = 1'b0;
        work_next.exp_half  = {e_unb[9], e_unb[7:1]};
        work_next.rem       = {2'd0, mant_adj, 1'b0};
        work_next.partial   = '0;
        work_next.root      = '0;
        work_next.bit_oh    = {1'b1, 24'd0};
        if ((operand_bits & ~fsr_pkg::SignMask) == 32'd0)
        begin
            work_next.special = 1'b1;
        end
        else if (operand_bits[31])
        begin
            work_next.special   = 1'b1;
            work_next.invalid   = 1'b1;
            work_next.spec_bits = fsr_pkg::DefaultNan;
        end
        else if (ex == 8'hff)
        begin
            work_next.special = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
        end
    end
endmodule

[hw/rtl/fsr_cell.sv]
// One restoring square root cell: decides one root bit and passes the work on.
// Depends on fsr_pkg.
module fsr_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  fsr_pkg::fsr_work_t work_in,
    output logic              valid_reg,
    output fsr_pkg::fsr_work_t work_reg
);
    fsr_pkg::fsr_work_t work_next;
    logic [fsr_pkg::RemBits-1:0] bit_w;
    logic [fsr_pkg::RemBits-1:0] trial;
    logic [fsr_pkg::RemBits-1:0] rem_sub;

    always_comb
    begin
        bit_w     = {3'd0, work_in.bit_oh};
        trial     = work_in.partial + bit_w;
        work_next = work_in;
        rem_sub   = work_in.rem;
        if (trial <= work_in.rem)
        begin
            work_next.partial = trial + bit_w;
            rem_sub           = work_in.rem - trial;
            work_next.root    = work_in.root | work_in.bit_oh;
        end
        work_next.rem    = {rem_sub[fsr_pkg::RemBits-2:0], 1'b0};
        work_next.bit_oh = work_in.bit_oh >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
        end
    end
endmodule

[hw/rtl/fsr_round.sv]
// Final stage: rounds the 25-bit root and packs the result with its flags.
// Depends on fsr_pkg.
module fsr_round (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  fsr_pkg::fsr_work_t work_in,
    input  logic [1:0]        mode,
    output logic              valid_reg,
    output logic [31:0]       bits_reg,
    output logic              invalid_reg,
    output logic              inexact_reg
);
    logic        inexact;
    logic [31:0] root_inc;
    logic [31:0] bits_next;

    always_comb
    begin
        inexact  = (work_in.rem != '0);
        root_inc = {7'd0, work_in.root};
        if (inexact)
        begin
            case (mode)
                fsr_pkg::RndNearest: root_inc = root_inc + {31'd0, work_in.root[0]};
                fsr_pkg::RndUp:      root_inc = root_inc + 32'd2;
                default:             root_inc = root_inc;
            endcase
        end
        bits_next = (root_inc >> 1) + fsr_pkg::HalfBias
                  + ({{24{work_in.exp_half[7]}}, work_in.exp_half} << 23);
        if (work_in.special)
        begin
            bits_next = work_in.spec_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bits_reg    <= bits_next;
            invalid_reg <= work_in.special & work_in.invalid;
            inexact_reg <= ~work_in.special & inexact;
        end
    end
endmodule

[hw/rtl/float32_square_root_core.sv]
// Single-precision square root core: an entry stage, a chain of 25 root cells, a round stage.
// One request per cycle is taken while the output is not stalled, set by the single
// shared advance of the whole chain.
// Reset clears all valid bits and sets the rounding mode to nearest even.
// Depends on fsr_pkg, fsr_norm, fsr_cell, fsr_round and the defines header.
`include "float32_square_root_core_defines.svh"
module float32_square_root_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] operand_bits,
    input  logic        rounding_mode_we,
    input  logic [1:0]  rounding_mode_wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] root_bits,
    output logic        invalid_flag,
    output logic        inexact_flag
);
    logic               en;
    logic [1:0]         mode_reg;
    logic               valid_chain [fsr_pkg::RootBits+1];
    fsr_pkg::fsr_work_t work_chain  [fsr_pkg::RootBits+1];

    // The whole chain moves together unless a finished result is held.
    assign en       = ~(out_valid & out_stall);
    assign in_stall = ~en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= fsr_pkg::RndNearest;
        end
        else if (rounding_mode_we)
        begin
            mode_reg <= rounding_mode_wdata;
        end
    end

    fsr_norm u_norm (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .operand_bits (operand_bits),
        .valid_reg    (valid_chain[0]),
        .work_reg     (work_chain[0])
    );

    for (genvar g = 0; g < fsr_pkg::RootBits; g++)
    begin : g_cell
        fsr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_chain[g]),
            .work_in   (work_chain[g]),
            .valid_reg (valid_chain[g+1]),
            .work_reg  (work_chain[g+1])
        );
    end

    fsr_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .valid_in    (valid_chain[fsr_pkg::RootBits]),
        .work_in     (work_chain[fsr_pkg::RootBits]),
        .mode        (mode_reg),
        .valid_reg   (out_valid),
        .bits_reg    (root_bits),
        .invalid_reg (invalid_flag),
        .inexact_reg (inexact_flag)
    );

    `FSR_ASSERT_NOW(a_nan_on_invalid, out_valid && invalid_flag, root_bits == fsr_pkg::DefaultNan)
    `FSR_ASSERT_NOW(a_flags_exclusive, out_valid, !(invalid_flag && inexact_flag))
    `FSR_ASSERT_NEXT(a_held_chain, out_valid && out_stall, out_valid)
endmodule
